// ===== hdl/cancrb_pkg.sv =====
// ----------------------------------------------------------------------------
// CAN controller register block - shared types and constants
// Word layouts, register map, status codes and receive FIFO sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package cancrb_pkg;

    localparam int RX_FIFO_DEPTH = 16;
    localparam int FRAME_BYTES   = 8;

    localparam int PTR_W = (RX_FIFO_DEPTH > 1) ? $clog2(RX_FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(RX_FIFO_DEPTH + 1);
    localparam int LEN_W = 4;

    localparam int CFG_ADDR_W = 3;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_FRAME = 2'd2;

    localparam logic [4:0] ADDR_CONTROL  = 5'd0;
    localparam logic [4:0] ADDR_STATUS   = 5'd1;
    localparam logic [4:0] ADDR_TX_ID    = 5'd2;
    localparam logic [4:0] ADDR_TX_LEN   = 5'd3;
    localparam logic [4:0] ADDR_TX_BYTE0 = 5'd4;
    localparam logic [4:0] ADDR_TX_BYTE7 = 5'd11;
    localparam logic [4:0] ADDR_RX_ID    = 5'd12;
    localparam logic [4:0] ADDR_RX_LEN   = 5'd13;
    localparam logic [4:0] ADDR_RX_BYTE0 = 5'd14;
    localparam logic [4:0] ADDR_RX_BYTE7 = 5'd21;

    localparam int CTRL_SEND_BIT = 0;
    localparam int CTRL_DROP_BIT = 1;

    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_READ_ONLY     = 3'd1;
    localparam logic [2:0] ST_BAD_ADDR      = 3'd2;
    localparam logic [2:0] ST_LEN_TOO_LARGE = 3'd3;
    localparam logic [2:0] ST_NOT_CONNECTED = 3'd4;
    localparam logic [2:0] ST_INVALID_FRAME = 3'd5;
    localparam logic [2:0] ST_FIFO_FULL     = 3'd6;

    localparam logic [0:0] CFG_IDX_BUS_CONNECTED = 1'b0;

    typedef struct packed {
        logic [1:0]  mode;
        logic [4:0]  address;
        logic [31:0] write_value;
        logic [31:0] rx_id;
        logic [3:0]  rx_length;
        logic [63:0] rx_payload;
    } in_word_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [2:0]  status;
        logic        tx_valid;
        logic [31:0] tx_id;
        logic [3:0]  tx_length;
        logic [63:0] tx_payload;
    } out_word_t;

    typedef struct packed {
        logic [31:0]      id;
        logic [LEN_W-1:0] length;
        logic [63:0]      payload;
    } rx_entry_t;

    typedef struct packed {
        logic      push;
        logic      pop;
        rx_entry_t entry;
    } fifo_ctrl_t;

    typedef struct packed {
        logic      not_empty;
        logic      full;
        rx_entry_t head;
    } fifo_stat_t;

endpackage

`default_nettype wire

// ===== hdl/cancrb_apb_regs.sv =====
// ----------------------------------------------------------------------------
// CAN controller register block - configuration port
// APB-style slave holding the bus connection flag.
// ----------------------------------------------------------------------------
`default_nettype none

module cancrb_apb_regs (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [cancrb_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                      pwdata,
    output logic      [31:0]                      prdata,
    output logic                                  pready,
    output logic                                  bus_connected
);

    logic bus_connected_reg;
    logic cfg_write;
    logic [0:0] reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bus_connected_reg <= 1'b0;
        end else if (cfg_write && reg_index == cancrb_pkg::CFG_IDX_BUS_CONNECTED) begin
            bus_connected_reg <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_index)
            cancrb_pkg::CFG_IDX_BUS_CONNECTED: begin
                prdata = {31'd0, bus_connected_reg};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign bus_connected = bus_connected_reg;

endmodule

`default_nettype wire

// ===== hdl/cancrb_rx_fifo.sv =====
// ----------------------------------------------------------------------------
// CAN controller register block - receive FIFO
// Circular frame store with head, tail and fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module cancrb_rx_fifo (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire cancrb_pkg::fifo_ctrl_t ctrl,
    output cancrb_pkg::fifo_stat_t      stat
);

    cancrb_pkg::rx_entry_t entries_reg [cancrb_pkg::RX_FIFO_DEPTH];

    logic [cancrb_pkg::PTR_W-1:0] head_reg;
    logic [cancrb_pkg::PTR_W-1:0] head_next;
    logic [cancrb_pkg::PTR_W-1:0] tail_reg;
    logic [cancrb_pkg::PTR_W-1:0] tail_next;
    logic [cancrb_pkg::CNT_W-1:0] count_reg;

    localparam logic [cancrb_pkg::PTR_W-1:0] LAST_SLOT =
        cancrb_pkg::PTR_W'(cancrb_pkg::RX_FIFO_DEPTH - 1);
    localparam logic [cancrb_pkg::CNT_W-1:0] FULL_COUNT =
        cancrb_pkg::CNT_W'(cancrb_pkg::RX_FIFO_DEPTH);

    assign head_next = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
    assign tail_next = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            entries_reg[tail_reg] <= ctrl.entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (ctrl.push) begin
                tail_reg <= tail_next;
            end
            if (ctrl.pop) begin
                head_reg <= head_next;
            end
            if (ctrl.push && !ctrl.pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (ctrl.pop && !ctrl.push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign stat.not_empty = (count_reg != '0);
    assign stat.full      = (count_reg == FULL_COUNT);
    assign stat.head      = entries_reg[head_reg];

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.push |-> count_reg != FULL_COUNT)
        else $error("push into a full receive FIFO");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.pop |-> count_reg != '0)
        else $error("pop from an empty receive FIFO");

    a_push_grows_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.push && !ctrl.pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("fill count did not follow a push");

    a_pop_moves_head: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.pop |=> head_reg == $past(head_next))
        else $error("head pointer did not advance on pop");

endmodule

`default_nettype wire

// ===== hdl/cancrb_exec.sv =====
// ----------------------------------------------------------------------------
// CAN controller register block - item execution
// Staged transmit frame and decode of writes, reads and frame events.
// ----------------------------------------------------------------------------
`default_nettype none

module cancrb_exec (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire cancrb_pkg::in_word_t   item,
    input  wire logic                   fire,
    input  wire logic                   bus_connected,
    input  wire cancrb_pkg::fifo_stat_t fifo_stat,
    output cancrb_pkg::out_word_t       result,
    output cancrb_pkg::fifo_ctrl_t      fifo_ctrl
);

    logic [31:0]                                staged_id_reg;
    logic [31:0]                                staged_id_next;
    logic [cancrb_pkg::LEN_W-1:0]               staged_length_reg;
    logic [cancrb_pkg::LEN_W-1:0]               staged_length_next;
    logic [cancrb_pkg::FRAME_BYTES-1:0][7:0]    staged_bytes_reg;
    logic [cancrb_pkg::FRAME_BYTES-1:0][7:0]    staged_bytes_next;

    logic [4:0] tx_offset;
    logic [4:0] rx_offset;
    logic [2:0] tx_idx;
    logic [2:0] rx_idx;
    logic       send_req;
    logic       send_blocked;

    assign tx_offset    = item.address - cancrb_pkg::ADDR_TX_BYTE0;
    assign rx_offset    = item.address - cancrb_pkg::ADDR_RX_BYTE0;
    assign tx_idx       = tx_offset[2:0];
    assign rx_idx       = rx_offset[2:0];
    assign send_req     = item.write_value[cancrb_pkg::CTRL_SEND_BIT];
    assign send_blocked = send_req && !bus_connected;

    always_comb begin
        result             = '0;
        fifo_ctrl          = '0;
        fifo_ctrl.entry    = '{id: item.rx_id, length: item.rx_length,
                               payload: item.rx_payload};
        staged_id_next     = staged_id_reg;
        staged_length_next = staged_length_reg;
        staged_bytes_next  = staged_bytes_reg;
        unique case (item.mode)
            cancrb_pkg::MODE_WRITE: begin
                unique case (item.address) inside
                    cancrb_pkg::ADDR_CONTROL: begin
                        if (send_blocked) begin
                            result.status = cancrb_pkg::ST_NOT_CONNECTED;
                        end else if (send_req) begin
                            result.tx_valid   = 1'b1;
                            result.tx_id      = staged_id_reg;
                            result.tx_length  = staged_length_reg;
                            result.tx_payload = staged_bytes_reg;
                        end
                        fifo_ctrl.pop = fire && !send_blocked && fifo_stat.not_empty
                                        && item.write_value[cancrb_pkg::CTRL_DROP_BIT];
                    end
                    cancrb_pkg::ADDR_TX_ID: begin
                        staged_id_next = item.write_value;
                    end
                    cancrb_pkg::ADDR_TX_LEN: begin
                        if (item.write_value > 32'(cancrb_pkg::FRAME_BYTES)) begin
                            result.status = cancrb_pkg::ST_LEN_TOO_LARGE;
                        end else begin
                            staged_length_next = item.write_value[cancrb_pkg::LEN_W-1:0];
                        end
                    end
                    [cancrb_pkg::ADDR_TX_BYTE0:cancrb_pkg::ADDR_TX_BYTE7]: begin
                        staged_bytes_next[tx_idx] = item.write_value[7:0];
                    end
                    cancrb_pkg::ADDR_STATUS,
                    [cancrb_pkg::ADDR_RX_ID:cancrb_pkg::ADDR_RX_BYTE7]: begin
                        result.status = cancrb_pkg::ST_READ_ONLY;
                    end
                    default: begin
                        result.status = cancrb_pkg::ST_BAD_ADDR;
                    end
                endcase
            end
            cancrb_pkg::MODE_READ: begin
                unique case (item.address) inside
                    cancrb_pkg::ADDR_CONTROL: begin
                        result.read_data = '0;
                    end
                    cancrb_pkg::ADDR_STATUS: begin
                        result.read_data = 32'(fifo_stat.not_empty);
                    end
                    cancrb_pkg::ADDR_TX_ID: begin
                        result.read_data = staged_id_reg;
                    end
                    cancrb_pkg::ADDR_TX_LEN: begin
                        result.read_data = 32'(staged_length_reg);
                    end
                    [cancrb_pkg::ADDR_TX_BYTE0:cancrb_pkg::ADDR_TX_BYTE7]: begin
                        result.read_data = 32'(staged_bytes_reg[tx_idx]);
                    end
                    cancrb_pkg::ADDR_RX_ID: begin
                        if (fifo_stat.not_empty) begin
                            result.read_data = fifo_stat.head.id;
                        end
                    end
                    cancrb_pkg::ADDR_RX_LEN: begin
                        if (fifo_stat.not_empty) begin
                            result.read_data = 32'(fifo_stat.head.length);
                        end
                    end
                    [cancrb_pkg::ADDR_RX_BYTE0:cancrb_pkg::ADDR_RX_BYTE7]: begin
                        if (fifo_stat.not_empty) begin
                            result.read_data =
                                32'(fifo_stat.head.payload[{rx_idx, 3'b000} +: 8]);
                        end
                    end
                    default: begin
                        result.status = cancrb_pkg::ST_BAD_ADDR;
                    end
                endcase
            end
            cancrb_pkg::MODE_FRAME: begin
                if (item.rx_length > cancrb_pkg::LEN_W'(cancrb_pkg::FRAME_BYTES)) begin
                    result.status = cancrb_pkg::ST_INVALID_FRAME;
                end else if (fifo_stat.full) begin
                    result.status = cancrb_pkg::ST_FIFO_FULL;
                end else begin
                    fifo_ctrl.push = fire;
                end
            end
            default: begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            staged_id_reg     <= '0;
            staged_length_reg <= '0;
            staged_bytes_reg  <= '0;
        end else if (fire) begin
            staged_id_reg     <= staged_id_next;
            staged_length_reg <= staged_length_next;
            staged_bytes_reg  <= staged_bytes_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/can_controller_register_block.sv =====
// ----------------------------------------------------------------------------
// CAN controller register block - top level
// Register front end of a CAN controller with a receive frame FIFO.
// ----------------------------------------------------------------------------
// s_ channel: one word per register write, register read or bus frame event.
// m_ channel: exactly one result word per input word, in order.
// APB port: register 0 holds the bus connection flag; write it while idle.
// A word accepted into the input register is executed once the output
// register is free, and its result is registered in the output register,
// which drives m_valid.
// Throughput: one word per cycle while the receiver keeps up. Execution is a
// single pass through the decode logic between the input and the result
// register; the receive FIFO head, tail and count update in that same cycle.
// When the receiver stalls, the result word holds in the output register, the
// next word waits in the input register and s_ready drops.
// Reset clears the staged frame, FIFO pointers, count, the connection flag and
// both valid flags; FIFO contents are left as they are.
// ----------------------------------------------------------------------------
`default_nettype none

module can_controller_register_block (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire cancrb_pkg::in_word_t              s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output cancrb_pkg::out_word_t                  m_data,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [cancrb_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                       pwdata,
    output logic      [31:0]                       prdata,
    output logic                                   pready
);

    logic                   in_valid_reg;
    cancrb_pkg::in_word_t   in_data_reg;
    logic                   out_valid_reg;
    cancrb_pkg::out_word_t  out_data_reg;
    logic                   fire;
    logic                   bus_connected;
    cancrb_pkg::out_word_t  result;
    cancrb_pkg::fifo_ctrl_t fifo_ctrl;
    cancrb_pkg::fifo_stat_t fifo_stat;

    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    cancrb_apb_regs u_apb_regs (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .bus_connected (bus_connected)
    );

    cancrb_exec u_exec (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item          (in_data_reg),
        .fire          (fire),
        .bus_connected (bus_connected),
        .fifo_stat     (fifo_stat),
        .result        (result),
        .fifo_ctrl     (fifo_ctrl)
    );

    cancrb_rx_fifo u_rx_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (fifo_ctrl),
        .stat    (fifo_stat)
    );

endmodule

`default_nettype wire
